// ===== design/ihb_pkg.sv =====
// Package for the IPv4 header builder: field widths, fixed header constants,
// register indices and the shared network configuration struct.
// No dependencies; every design file refers to it by scoped names.
package ihb_pkg;

	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned PROTO_W   = 8;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned SENT_W    = 11;
	localparam int unsigned IDENT_W   = 16;
	localparam int unsigned HALF_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 208;

	localparam logic [SENT_W-1:0]  MAX_PAYLOAD   = 11'd1480;
	localparam logic [LEN_W-1:0]   HDR_BYTES     = 16'd20;
	localparam logic [7:0]         VER_IHL       = 8'h45;
	localparam logic [7:0]         TOS           = 8'h00;
	localparam logic [HALF_W-1:0]  FLAGS_FRAG    = 16'h4000;
	localparam logic [7:0]         TTL           = 8'd64;
	localparam logic [ADDR_W-1:0]  BCAST_ADDR    = 32'hFFFF_FFFF;
	localparam logic [IDENT_W-1:0] IDENT_RESET   = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_IP         = 2'd0,
		REG_SUBNET_MASK    = 2'd1,
		REG_GATEWAY_IP     = 2'd2,
		REG_NET_CONFIGURED = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] src_ip;
		logic [ADDR_W-1:0] subnet_mask;
		logic [ADDR_W-1:0] gateway_ip;
		logic              net_configured;
	} net_cfg_t;

endpackage

// ===== design/ihb_csum.sv =====
// Header checksum: ones-complement sum of the nine non-checksum 16-bit header
// halves, two end-around folds, then inversion. Uses ihb_pkg.
module ihb_csum (
	input  logic [ihb_pkg::LEN_W-1:0]   total_len,
	input  logic [ihb_pkg::IDENT_W-1:0] ident,
	input  logic [ihb_pkg::PROTO_W-1:0] protocol,
	input  logic [ihb_pkg::ADDR_W-1:0]  src_ip,
	input  logic [ihb_pkg::ADDR_W-1:0]  dest_ip,
	output logic [ihb_pkg::HALF_W-1:0]  checksum
);

	// Nine 16-bit terms fit in 20 bits.
	logic [19:0] sum_raw;
	logic [16:0] fold1;
	logic [15:0] fold2;

	always_comb begin
		sum_raw = 20'({ihb_pkg::VER_IHL, ihb_pkg::TOS})
			+ 20'(total_len)
			+ 20'(ident)
			+ 20'(ihb_pkg::FLAGS_FRAG)
			+ 20'({ihb_pkg::TTL, protocol})
			+ 20'(src_ip[31:16]) + 20'(src_ip[15:0])
			+ 20'(dest_ip[31:16]) + 20'(dest_ip[15:0]);
		fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[19:16]);
		fold2 = fold1[15:0] + 16'(fold1[16]);
		checksum = ~fold2;
	end

endmodule

// ===== design/ihb_hop.sv =====
// Next-hop selection: broadcast, local subnet or unconfigured stack go
// direct, everything else goes to the gateway. Uses ihb_pkg.
module ihb_hop (
	input  ihb_pkg::net_cfg_t          cfg,
	input  logic [ihb_pkg::ADDR_W-1:0] dest_ip,
	output logic [ihb_pkg::ADDR_W-1:0] route_ip
);

	logic on_subnet;

	always_comb begin
		on_subnet = (dest_ip & cfg.subnet_mask) == (cfg.src_ip & cfg.subnet_mask);
		if (dest_ip == ihb_pkg::BCAST_ADDR) begin
			route_ip = ihb_pkg::BCAST_ADDR;
		end else if (cfg.net_configured && !on_subnet) begin
			route_ip = cfg.gateway_ip;
		end else begin
			route_ip = dest_ip;
		end
	end

endmodule

// ===== design/ipv4_header_builder.sv =====
// An accepted request beat goes into the input register, then into the result register,
// which drives the output. One header per cycle unless the output stalls; while a
// finished header waits, the input takes one more beat, then waits for the output to drain.
// Reset (arst_n low) empties both stages, clears all configuration registers to
// zero and sets the identification counter to one.
module ipv4_header_builder (
	input  logic                              clk,
	input  logic                              arst_n,

	// Request stream. tdata, lowest bit up: dest_ip[31:0], protocol[39:32],
	// payload_length[55:40].
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ihb_pkg::IN_DATA_W-1:0]     s_axis_tdata,

	// Header stream. tdata, lowest bit up: header_word0[31:0], header_word1[63:32],
	// header_word2[95:64], header_word3[127:96], header_word4[159:128],
	// link-layer hop address[191:160], sent_length[202:192], zero padding [207:203].
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ihb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ihb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ihb_pkg::ADDR_W-1:0]        cfg_data
);

	// Configuration registers. Writes are always taken; software must change them only while
	// the block is idle (the block does not enforce this), so both stages may read them freely.
	ihb_pkg::net_cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (ihb_pkg::cfg_reg_t'(cfg_index))
				ihb_pkg::REG_SRC_IP:         cfg_q.src_ip <= cfg_data;
				ihb_pkg::REG_SUBNET_MASK:    cfg_q.subnet_mask <= cfg_data;
				ihb_pkg::REG_GATEWAY_IP:     cfg_q.gateway_ip <= cfg_data;
				ihb_pkg::REG_NET_CONFIGURED: cfg_q.net_configured <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake. The result stage loads whenever it is empty or being drained; the input
	// stage moves on whenever it is empty or the result stage takes its beat.
	logic valid_s1, valid_s2;
	logic load_s2, load_s1;

	assign load_s2       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || load_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// The identification is claimed when the request is accepted, so headers
	// carry consecutive values in acceptance order. It wraps at 16 bits.
	logic [ihb_pkg::IDENT_W-1:0] next_ident_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ident_q <= ihb_pkg::IDENT_RESET;
		end else if (load_s1) begin
			next_ident_q <= next_ident_q + 1'b1;
		end
	end

	// Input stage: the request, its identification and the clamped length.
	logic [ihb_pkg::ADDR_W-1:0]  dest_ip_s1;
	logic [ihb_pkg::PROTO_W-1:0] protocol_s1;
	logic [ihb_pkg::SENT_W-1:0]  sent_len_s1;
	logic [ihb_pkg::IDENT_W-1:0] ident_s1;
	logic [ihb_pkg::LEN_W-1:0]   req_len;

	assign req_len = s_axis_tdata[55:40];

	always_ff @(posedge clk) begin
		if (load_s1) begin
			dest_ip_s1  <= s_axis_tdata[31:0];
			protocol_s1 <= s_axis_tdata[39:32];
			ident_s1    <= next_ident_q;
			if (req_len > ihb_pkg::LEN_W'(ihb_pkg::MAX_PAYLOAD)) begin
				sent_len_s1 <= ihb_pkg::MAX_PAYLOAD;
			end else begin
				sent_len_s1 <= req_len[ihb_pkg::SENT_W-1:0];
			end
		end
	end

	// Header assembly between the two registers: total length, checksum and
	// the hop address are all short functions of the stored request.
	logic [ihb_pkg::LEN_W-1:0]  total_len;
	logic [ihb_pkg::HALF_W-1:0] checksum;
	logic [ihb_pkg::ADDR_W-1:0] route_ip;

	assign total_len = ihb_pkg::HDR_BYTES + ihb_pkg::LEN_W'(sent_len_s1);

	ihb_csum u_csum (
		.total_len (total_len),
		.ident     (ident_s1),
		.protocol  (protocol_s1),
		.src_ip    (cfg_q.src_ip),
		.dest_ip   (dest_ip_s1),
		.checksum  (checksum)
	);

	ihb_hop u_hop (
		.cfg      (cfg_q),
		.dest_ip  (dest_ip_s1),
		.route_ip (route_ip)
	);

	// Result stage.
	logic [ihb_pkg::ADDR_W-1:0] word0_s2, word1_s2, word2_s2, word3_s2, word4_s2;
	logic [ihb_pkg::ADDR_W-1:0] hop_s2;
	logic [ihb_pkg::SENT_W-1:0] sent_len_s2;

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			word0_s2    <= {ihb_pkg::VER_IHL, ihb_pkg::TOS, total_len};
			word1_s2    <= {ident_s1, ihb_pkg::FLAGS_FRAG};
			word2_s2    <= {ihb_pkg::TTL, protocol_s1, checksum};
			word3_s2    <= cfg_q.src_ip;
			word4_s2    <= dest_ip_s1;
			hop_s2      <= route_ip;
			sent_len_s2 <= sent_len_s1;
		end
	end

	assign m_axis_tdata = {5'b0, sent_len_s2, hop_s2, word4_s2, word3_s2, word2_s2,
		word1_s2, word0_s2};

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for ipv4_header_builder: drives send requests and network settings,
// predicts every header, hop address and clamped length, and compares each header beat.
// Depends on ihb_pkg for port widths and register indices, and on the block itself.
module testbench;

	// The block's cap on payload bytes and the fixed header fields it inserts.
	localparam int unsigned    PAYLOAD_CAP  = 1480;
	localparam logic [15:0]    HEADER_BYTES = 16'd20;
	localparam logic [7:0]     VERSION_IHL  = 8'h45;
	localparam logic [7:0]     SERVICE_TYPE = 8'h00;
	localparam logic [15:0]    DONT_FRAG    = 16'h4000;
	localparam logic [7:0]     HOP_LIMIT    = 8'd64;
	localparam logic [31:0]    ALL_ONES     = 32'hFFFF_FFFF;

	localparam logic [7:0]     PROTO_ICMP   = 8'd1;
	localparam logic [7:0]     PROTO_TCP    = 8'd6;
	localparam logic [7:0]     PROTO_UDP    = 8'd17;

	localparam int             RAND_PHASES  = 8;
	localparam int             PHASE_ITEMS  = 130;
	// Requests in total once the closing back-to-back run has topped the count up.
	localparam int             ITEM_TOTAL   = 1150;
	localparam int             SETTLE_EDGES = 6;
	localparam int             CYCLE_LIMIT  = 600000;

	typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

	typedef struct packed {
		logic [31:0] dest_ip;
		logic [7:0]  protocol;
		logic [15:0] payload_length;
		logic        wait_drain;
	} send_req_t;

	typedef struct packed {
		logic [31:0] word0;
		logic [31:0] word1;
		logic [31:0] word2;
		logic [31:0] word3;
		logic [31:0] word4;
		logic [31:0] route;
		logic [10:0] sent_length;
	} header_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;

	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [ihb_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;

	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [ihb_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ihb_pkg::CFG_IDX_W-1:0]   cfg_index = ihb_pkg::REG_SRC_IP;
	logic [ihb_pkg::ADDR_W-1:0]      cfg_data = '0;

	// The bench's own copy of the network settings and the identification counter.
	logic [31:0]            net_src = '0;
	logic [31:0]            net_mask = '0;
	logic [31:0]            net_gateway = '0;
	logic                   net_up = 1'b0;
	logic [15:0]            ident_next = 16'd1;

	send_req_t              send_queue[$];
	header_t                header_q[$];
	send_req_t              on_bus;
	header_t                predicted;
	header_t                want;

	int                     src_idle_pct = 0;
	int                     rcv_stall_pct = 0;
	int                     err_count = 0;
	int                     n_pushed = 0;
	int                     n_checked = 0;
	int                     n_cfg_writes = 0;
	int                     n_settings = 0;
	int                     n_bcast = 0;
	int                     n_gateway = 0;
	int                     n_clamped = 0;
	int                     n_wraps = 0;
	int                     cycle_count = 0;

	ipv4_header_builder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicts the header for one request. The length is clamped first, so the total
	// length and the checksum both see the clamped value. The checksum is the ones'
	// complement sum of the nine non-checksum halfwords, folded twice, then inverted.
	function automatic header_t build_header(send_req_t r, logic [15:0] ident);
		header_t     h;
		logic [10:0] len;
		logic [15:0] total;
		logic [31:0] acc;
		if (r.payload_length > PAYLOAD_CAP) begin
			len = 11'(PAYLOAD_CAP);
		end else begin
			len = r.payload_length[10:0];
		end
		total = HEADER_BYTES + 16'(len);
		h.word0 = {VERSION_IHL, SERVICE_TYPE, total};
		h.word1 = {ident, DONT_FRAG};
		acc = 32'({VERSION_IHL, SERVICE_TYPE}) + 32'(total) + 32'(ident) + 32'(DONT_FRAG)
			+ 32'({HOP_LIMIT, r.protocol})
			+ 32'(net_src[31:16]) + 32'(net_src[15:0])
			+ 32'(r.dest_ip[31:16]) + 32'(r.dest_ip[15:0]);
		acc = 32'(acc[15:0]) + 32'(acc[31:16]);
		acc = 32'(acc[15:0]) + 32'(acc[31:16]);
		h.word2 = {HOP_LIMIT, r.protocol, ~acc[15:0]};
		h.word3 = net_src;
		h.word4 = r.dest_ip;
		// Broadcast wins over everything; an unconfigured stack sends straight to the
		// destination; otherwise off-subnet traffic goes through the gateway.
		if (r.dest_ip == ALL_ONES) begin
			h.route = ALL_ONES;
		end else if (net_up && ((r.dest_ip & net_mask) != (net_src & net_mask))) begin
			h.route = net_gateway;
		end else begin
			h.route = r.dest_ip;
		end
		h.sent_length = len;
		return h;
	endfunction

	function automatic void push_request(logic [31:0] dest, logic [7:0] proto,
		logic [15:0] len, logic drain);
		send_req_t r;
		r.dest_ip = dest;
		r.protocol = proto;
		r.payload_length = len;
		r.wait_drain = drain;
		send_queue.push_back(r);
		n_pushed++;
	endfunction

	// Random request biased towards the interesting routes and lengths under the
	// current settings, while still covering every bit of every field.
	function automatic void push_random(logic drain);
		logic [31:0] dest;
		logic [7:0]  proto;
		logic [15:0] len;
		case ($urandom_range(15))
			0:          dest = ALL_ONES;
			1, 2, 3, 4,
			5, 6:       dest = (net_src & net_mask) | ($urandom() & ~net_mask);
			7:          dest = net_gateway;
			8:          dest = '0;
			default:    dest = $urandom();
		endcase
		case ($urandom_range(9))
			0:       len = 16'd0;
			1:       len = 16'(PAYLOAD_CAP);
			2:       len = 16'(PAYLOAD_CAP + 1);
			3:       len = 16'hFFFF;
			4, 5:    len = 16'($urandom());
			default: len = 16'($urandom_range(PAYLOAD_CAP));
		endcase
		case ($urandom_range(7))
			0:       proto = PROTO_ICMP;
			1:       proto = PROTO_TCP;
			2:       proto = PROTO_UDP;
			default: proto = 8'($urandom_range(255));
		endcase
		push_request(dest, proto, len, drain);
	endfunction

	function automatic void compare_field(string name, logic [31:0] exp_val,
		logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
			err_count++;
		end
	endfunction

	function automatic void set_pacing(pace_t mode);
		case (mode)
			PACE_NONE: begin
				src_idle_pct = 0;
				rcv_stall_pct = 0;
			end
			PACE_SENDER: begin
				src_idle_pct = 51;
				rcv_stall_pct = 0;
			end
			PACE_RECEIVER: begin
				src_idle_pct = 0;
				rcv_stall_pct = 51;
			end
			default: begin
				src_idle_pct = 14;
				rcv_stall_pct = 14;
			end
		endcase
	endfunction

	// Request driver. A beat accepted at this edge is predicted before the next one is
	// put on the bus. A request marked to wait for the drain is held back until every
	// header already sent has come out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = build_header(on_bus, ident_next);
				header_q.push_back(predicted);
				if (on_bus.dest_ip == ALL_ONES) begin
					n_bcast++;
				end else if (predicted.route != on_bus.dest_ip) begin
					n_gateway++;
				end
				if (on_bus.payload_length > PAYLOAD_CAP) begin
					n_clamped++;
				end
				ident_next = ident_next + 16'd1;
				if (ident_next == 16'd0) begin
					n_wraps++;
				end
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_queue.size() != 0
					&& !(send_queue[0].wait_drain && header_q.size() != 0)
					&& $urandom_range(99) >= src_idle_pct) begin
					on_bus = send_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {on_bus.payload_length, on_bus.protocol, on_bus.dest_ip};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Header monitor. Every accepted beat is checked against the oldest prediction,
	// field by field; tready is redrawn on every edge to stall the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (header_q.size() == 0) begin
					$error("header beat 0x%052h arrived with no request outstanding",
						m_axis_tdata);
					err_count++;
				end else begin
					want = header_q.pop_front();
					compare_field("header_word0", want.word0, m_axis_tdata[31:0]);
					compare_field("header_word1", want.word1, m_axis_tdata[63:32]);
					compare_field("header_word2", want.word2, m_axis_tdata[95:64]);
					compare_field("header_word3", want.word3, m_axis_tdata[127:96]);
					compare_field("header_word4", want.word4, m_axis_tdata[159:128]);
					compare_field("hop address", want.route, m_axis_tdata[191:160]);
					compare_field("sent_length", 32'(want.sent_length),
						32'(m_axis_tdata[202:192]));
					n_checked++;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Watchdog: the slowest legal run is far shorter than this.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timed out with %0d requests queued and %0d headers outstanding",
				send_queue.size(), header_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// One register write over the configuration channel; the bench's copy follows it.
	task automatic write_reg(ihb_pkg::cfg_reg_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ihb_pkg::REG_SRC_IP:         net_src = value;
			ihb_pkg::REG_SUBNET_MASK:    net_mask = value;
			ihb_pkg::REG_GATEWAY_IP:     net_gateway = value;
			ihb_pkg::REG_NET_CONFIGURED: net_up = value[0];
			default: ;
		endcase
		n_cfg_writes++;
	endtask

	task automatic set_network(logic [31:0] src, logic [31:0] mask, logic [31:0] gw,
		logic up);
		write_reg(ihb_pkg::REG_SRC_IP, src);
		write_reg(ihb_pkg::REG_SUBNET_MASK, mask);
		write_reg(ihb_pkg::REG_GATEWAY_IP, gw);
		write_reg(ihb_pkg::REG_NET_CONFIGURED, {31'd0, up});
		n_settings++;
	endtask

	// Waits until every queued request has gone in and every header has come out, then
	// lets the two-stage pipeline run empty before anything else happens.
	task automatic settle();
		while (send_queue.size() != 0 || s_axis_tvalid || header_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_EDGES) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Straight after reset the stack is unconfigured with a zero source address:
		// every destination is its own next hop. Length extremes, including values just
		// either side of the cap, and protocol extremes go through here.
		n_settings++;
		push_request(32'h0000_0000, 8'd0, 16'd0, 1'b0);
		push_request(ALL_ONES, 8'hFF, 16'hFFFF, 1'b0);
		push_request(32'hC0A8_0105, PROTO_TCP, 16'(PAYLOAD_CAP), 1'b0);
		push_request(32'h1234_5678, PROTO_UDP, 16'(PAYLOAD_CAP + 1), 1'b1);
		push_request(32'hAAAA_5555, PROTO_ICMP, 16'(PAYLOAD_CAP - 1), 1'b0);
		push_request(32'h5555_AAAA, 8'h80, 16'h8000, 1'b0);
		settle();

		// A typical /24 network: on-subnet, off-subnet, broadcast, the gateway itself,
		// our own address and the subnet's directed broadcast, which is not all-ones.
		set_network(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 1'b1);
		set_pacing(PACE_BOTH);
		push_request(32'hC0A8_014D, PROTO_ICMP, 16'd64, 1'b0);
		push_request(32'h0808_0808, PROTO_TCP, 16'd1000, 1'b0);
		push_request(ALL_ONES, PROTO_UDP, 16'd0, 1'b0);
		push_request(32'hC0A8_0101, PROTO_TCP, 16'd1, 1'b0);
		push_request(32'hC0A8_010A, PROTO_UDP, 16'd20, 1'b1);
		push_request(32'hC0A8_01FF, PROTO_UDP, 16'd512, 1'b0);
		push_request(32'h0000_0000, 8'h00, 16'hFFFF, 1'b0);
		push_request(32'hC0A8_020A, 8'hFF, 16'(PAYLOAD_CAP + 1), 1'b0);
		settle();

		// Random phases, each under its own settings and pacing. Extremes come first:
		// a zero mask puts everything on-subnet, an all-ones mask only our own address,
		// and an unconfigured stack with real values must ignore the gateway.
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: set_network(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 1'b1);
				1: set_network(32'h0A00_0005, 32'h0000_0000, 32'h0A00_0001, 1'b1);
				2: set_network(ALL_ONES, ALL_ONES, 32'hFFFF_FFFE, 1'b1);
				3: set_network(32'hAC10_0402, 32'hFFFF_0000, 32'hAC10_0001, 1'b0);
				4: set_network(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
				default: set_network($urandom(), ALL_ONES << $urandom_range(32), $urandom(),
					1'b1);
			endcase
			set_pacing(pace_t'(p % 4));
			// One request part-way through waits until the output has fully drained.
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				push_random(i == PHASE_ITEMS / 3);
			end
			settle();
		end

		// A closing back-to-back run with no stalls on either side.
		set_network(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 1'b1);
		set_pacing(PACE_NONE);
		while (n_pushed < ITEM_TOTAL) begin
			push_random(1'b0);
		end
		settle();

		$display("Checked %0d headers under %0d network settings (%0d register writes).",
			n_checked, n_settings, n_cfg_writes);
		$display("%0d broadcast, %0d via gateway, %0d lengths clamped, %0d identification wrap(s).",
			n_bcast, n_gateway, n_clamped, n_wraps);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/ihb_pkg.sv
design/ihb_csum.sv
design/ihb_hop.sv
design/ipv4_header_builder.sv
tb/testbench.sv
